/* design/pidf_pkg.sv */
// pidf_pkg: shared widths and register index codes for the filtered-derivative
// incremental PID block. No dependencies.
package pidf_pkg;

   localparam int DATA_W    = 16;   // gains, setpoint, measured sample, drive
   localparam int LIMIT_W   = 15;   // drive_limit
   localparam int SMOOTH_W  = 13;   // deriv_smoothing, Q1.12
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_BITS = 8;
   localparam int Q12_SHIFT = 12;

   // derived internal widths
   localparam int ERR_W   = DATA_W + 1;    // setpoint - measured
   localparam int DP_W    = ERR_W + 1;     // first difference
   localparam int DD_W    = ERR_W + 2;     // second difference
   localparam int DERIV_W = 35;            // gain_d * second difference
   localparam int DF_W    = 36;            // filtered derivative
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = DATA_W + 1;
   localparam int PROD_W  = 48;
   localparam int SUM_W   = 38;
   localparam int ACC_W   = 32;

   localparam logic [SMOOTH_W-1:0] Q12_ONE = SMOOTH_W'(4096);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_LIMIT = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING   = CSR_IDX_W'(5);

endpackage

/* design/incremental_pid_filtered_d.sv */
// incremental_pid_filtered_d: velocity-form PID with low-passed derivative,
// built around one shared 36x17 multiplier under a small sequencer.
// Depends on pidf_pkg.
//
//  channel | ports                                  | dir | handshake
//  --------+----------------------------------------+-----+----------------------
//  request | req_valid req_ready req_measured       | in  | valid/ready, 1 word
//  result  | rsp_valid rsp_ready rsp_drive rsp_clamped | out | valid/ready, 1 word
//  config  | csr_valid csr_ready csr_index csr_data | in  | valid/ready, always ready
//
// After acceptance, one sample makes five passes through the
// shared multiplier (derivative, two filter products, proportional, integral),
// then a final add and the clamp. The result sits in an output register;
// a new sample is accepted while it waits. If the previous result is still
// unclaimed at clamp time, the sequencer holds there until it is taken.
// Synchronous active-high reset clears gains, setpoint, smoothing and all
// loop state, and sets drive_limit to 32767.
module incremental_pid_filtered_d (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pidf_pkg::DATA_W-1:0]   req_measured,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pidf_pkg::DATA_W-1:0]   rsp_drive,
   output logic                                 rsp_clamped,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [pidf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [pidf_pkg::DATA_W-1:0]   csr_data
);
   import pidf_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DERIV  = 3'd1;
   localparam logic [2:0] ST_MIXOLD = 3'd2;
   localparam logic [2:0] ST_MIXNEW = 3'd3;
   localparam logic [2:0] ST_PROP   = 3'd4;
   localparam logic [2:0] ST_INTEG  = 3'd5;
   localparam logic [2:0] ST_SUMI   = 3'd6;
   localparam logic [2:0] ST_CLAMP  = 3'd7;

   // configuration
   logic signed [DATA_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff, setpoint_ff;
   logic        [LIMIT_W-1:0]  drive_limit_ff;
   logic        [SMOOTH_W-1:0] smoothing_ff;

   // loop state
   logic [2:0]                 state_ff, state_in;
   logic signed [ERR_W-1:0]    err_prev_ff, err_prev2_ff;
   logic signed [DF_W-1:0]     df_ff;
   logic signed [ACC_W-1:0]    accum_ff;

   // per-sample working registers
   logic signed [ERR_W-1:0]    err_ff;
   logic signed [DP_W-1:0]     dp_ff;
   logic signed [DD_W-1:0]     dd_ff;
   logic signed [DERIV_W-1:0]  deriv_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   mix_ff;
   logic signed [SUM_W-1:0]    sum_ff;

   logic                       rsp_valid_ff;
   logic signed [DATA_W-1:0]   rsp_drive_ff;
   logic                       rsp_clamped_ff;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       finish;
   logic signed [ERR_W-1:0]    err_new;
   logic [SMOOTH_W-1:0]        s_sat;
   logic [SMOOTH_W-1:0]        s_comp;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
   logic signed [PROD_W-1:0]   mix_sum;
   logic signed [SUM_W-1:0]    lim_pos, lim_neg;
   logic signed [SUM_W-1:0]    acc_clamped;
   logic                       hit;
   logic signed [ACC_W-FRAC_BITS-1:0] drive_trunc;

   assign csr_ready   = 1'b1;
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid_ff && rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

   // clamp can retire only if the output register is free this cycle
   assign finish = (state_ff == ST_CLAMP) && (!rsp_valid_ff || rsp_ready);

   assign err_new = ERR_W'(setpoint_ff) - ERR_W'(req_measured);
   assign s_sat   = (smoothing_ff > Q12_ONE) ? Q12_ONE : smoothing_ff;
   assign s_comp  = Q12_ONE - s_sat;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DERIV: begin
            mul_a = MUL_A_W'(dd_ff);
            mul_b = MUL_B_W'(gain_d_ff);
         end
         ST_MIXOLD: begin
            mul_a = MUL_A_W'(df_ff);
            mul_b = $signed({{(MUL_B_W-SMOOTH_W){1'b0}}, s_sat});
         end
         ST_MIXNEW: begin
            mul_a = MUL_A_W'(deriv_ff);
            mul_b = $signed({{(MUL_B_W-SMOOTH_W){1'b0}}, s_comp});
         end
         ST_PROP: begin
            mul_a = MUL_A_W'(dp_ff);
            mul_b = MUL_B_W'(gain_p_ff);
         end
         ST_INTEG: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(gain_i_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[PROD_W-1:0];

   // round to nearest, ties up: add half an LSB, then floor shift
   assign mix_sum = mix_ff + prod_ff + PROD_W'(2048);

   assign lim_pos = $signed({{(SUM_W-LIMIT_W-FRAC_BITS){1'b0}}, drive_limit_ff,
                             {FRAC_BITS{1'b0}}});
   assign lim_neg = -lim_pos;

   always_comb begin
      hit         = 1'b0;
      acc_clamped = sum_ff;
      if (sum_ff > lim_pos) begin
         hit         = 1'b1;
         acc_clamped = lim_pos;
      end else if (sum_ff < lim_neg) begin
         hit         = 1'b1;
         acc_clamped = lim_neg;
      end
   end

   // truncate toward zero: floor shift, then bump negatives with a fraction
   always_comb begin
      drive_trunc = acc_clamped[ACC_W-1:FRAC_BITS];
      if (acc_clamped[SUM_W-1] && (acc_clamped[FRAC_BITS-1:0] != '0)) begin
         drive_trunc = drive_trunc + (ACC_W-FRAC_BITS)'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_DERIV;
         ST_DERIV:  state_in = ST_MIXOLD;
         ST_MIXOLD: state_in = ST_MIXNEW;
         ST_MIXNEW: state_in = ST_PROP;
         ST_PROP:   state_in = ST_INTEG;
         ST_INTEG:  state_in = ST_SUMI;
         ST_SUMI:   state_in = ST_CLAMP;
         ST_CLAMP:  if (finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         setpoint_ff    <= '0;
         drive_limit_ff <= {LIMIT_W{1'b1}};
         smoothing_ff   <= '0;
         err_prev_ff    <= '0;
         err_prev2_ff   <= '0;
         df_ff          <= '0;
         accum_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAIN_P:      gain_p_ff      <= csr_data;
               REG_GAIN_I:      gain_i_ff      <= csr_data;
               REG_GAIN_D:      gain_d_ff      <= csr_data;
               REG_SETPOINT:    setpoint_ff    <= csr_data;
               REG_DRIVE_LIMIT: drive_limit_ff <= csr_data[LIMIT_W-1:0];
               REG_SMOOTHING:   smoothing_ff   <= csr_data[SMOOTH_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_PROP) begin
            df_ff <= mix_sum[PROD_W-1:Q12_SHIFT];
         end
         if (finish) begin
            accum_ff     <= acc_clamped[ACC_W-1:0];
            err_prev2_ff <= err_prev_ff;
            err_prev_ff  <= err_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (req_fire) begin
         err_ff <= err_new;
         dp_ff  <= DP_W'(err_new) - DP_W'(err_prev_ff);
         dd_ff  <= DD_W'(err_new) - (DD_W'(err_prev_ff) <<< 1) + DD_W'(err_prev2_ff);
      end
      case (state_ff)
         ST_MIXOLD: deriv_ff <= prod_ff[DERIV_W-1:0];
         ST_MIXNEW: mix_ff   <= prod_ff;
         ST_INTEG:  sum_ff   <= SUM_W'(accum_ff) + SUM_W'(df_ff) + prod_ff[SUM_W-1:0];
         ST_SUMI:   sum_ff   <= sum_ff + prod_ff[SUM_W-1:0];
         default: ;
      endcase
      if (finish) begin
         rsp_drive_ff   <= drive_trunc[DATA_W-1:0];
         rsp_clamped_ff <= hit;
      end
   end

   // a new result word appears only right after the clamp step
   a_rsp_from_clamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CLAMP)
      else $error("result word raised outside clamp step");

   // an accepted sample starts the multiplier sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DERIV)
      else $error("accepted sample did not start sequence");

   // hold the clamp step while the previous word is unclaimed
   a_clamp_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == ST_CLAMP && $stable(accum_ff)))
      else $error("clamp step retired over a pending word");

   // error history shifts once per finished sample
   a_err_shift: assert property (@(posedge clock) disable iff (reset)
      finish |=> err_prev2_ff == $past(err_prev_ff))
      else $error("error history did not shift");

endmodule
